### rtl/core/qslerp_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the quaternion slerp pipeline: field widths, register
// map and the Q30 arctangent table used by both CORDIC sections. No dependencies.
package qslerp_pkg;

    localparam int QW    = 16;  // quaternion component width
    localparam int TW    = 15;  // interpolation weight width
    localparam int THR_W = 15;  // near_threshold width

    // Register map, indexed by word address
    localparam logic REG_NEAR_THR = 1'b0;
    localparam logic [THR_W-1:0] NEAR_THR_RESET = 15'd2;

    // atan(2^-i) in Q30, truncated
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // Inverse CORDIC gain, Q30
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

endpackage

### rtl/core/quaternion_slerp_interpolator.sv
`timescale 1ns / 1ps
// Top level of the quaternion slerp interpolator: full datapath pipeline and
// the APB register for near_threshold. Depends on qslerp_pkg.

// Accepts one quaternion pair per clock and returns one interpolated
// quaternion per clock while no stall holds the pipe. Its stages include the
// square root (one root bit per stage), the two CORDIC sections (one
// micro-rotation per stage) and the restoring divider (one quotient bit per
// stage). The whole pipe advances when the output stage is empty or taken, so
// out_ready back-pressure stalls every stage together.
// near_threshold may only be written while no beat is in flight.
module quaternion_slerp_interpolator
    import qslerp_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 14
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [QW-1:0] p_w,
    input  logic signed [QW-1:0] p_x,
    input  logic signed [QW-1:0] p_y,
    input  logic signed [QW-1:0] p_z,
    input  logic signed [QW-1:0] q_w,
    input  logic signed [QW-1:0] q_x,
    input  logic signed [QW-1:0] q_y,
    input  logic signed [QW-1:0] q_z,
    input  logic [TW-1:0]        t_weight,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [QW-1:0] out_w,
    output logic signed [QW-1:0] out_x,
    output logic signed [QW-1:0] out_y,
    output logic signed [QW-1:0] out_z,
    output logic                 used_linear
);

    localparam int F     = FRAC_BITS;
    localparam int N     = CORDIC_STEPS;
    localparam longint ONE = longint'(1) << F;
    localparam int CW    = F + 1;          // cosine / root width
    localparam int RW    = 2 * CW;         // radicand width
    localparam int RMW   = F + 3;          // root remainder width
    localparam int SB    = CW;             // root bits
    localparam int XW    = F + 3;          // CORDIC datapath width
    localparam int NW    = XW + F;         // dividend width
    localparam int QB    = NW;             // quotient bits
    localparam int DRW   = CW + 1;         // divider remainder width
    localparam int WW    = F + 3;          // weight width
    localparam int MW    = WW + QW + 1;    // weighted product width
    localparam int SH    = 30 - F;
    localparam longint HALF_Q = (longint'(1) << SH) >>> 1;
    localparam longint X0_L = (longint'(CORDIC_GAIN_Q30) + HALF_Q) >>> SH;

    // stage indices
    localparam int P_MUL = 0;
    localparam int P_DOT = 1;
    localparam int P_RAD = 2;
    localparam int P_SQ  = 3;
    localparam int P_VC  = P_SQ + SB;
    localparam int P_AM  = P_VC + N;
    localparam int P_RC  = P_AM + 1;
    localparam int P_DA  = P_RC + N;
    localparam int P_DV  = P_DA + 1;
    localparam int P_WF  = P_DV + QB;
    localparam int P_WM  = P_WF + 1;
    localparam int P_OUT = P_WM + 1;
    localparam int NSTG  = P_OUT + 1;

    typedef struct packed {
        logic [3:0][QW-1:0] p;
        logic [3:0][QW:0]   q;
        logic [TW-1:0]      t;
        logic [CW-1:0]      c;
        logic [CW-1:0]      s;
        logic               lin;
    } side_t;

    logic adv;
    logic vld_reg [NSTG];
    side_t side_reg [P_OUT];
    side_t side_next [P_OUT];
    side_t side_in;

    logic [THR_W-1:0] thr_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= NEAR_THR_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_NEAR_THR)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NEAR_THR: prdata = {{(32-THR_W){1'b0}}, thr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign adv       = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < P_OUT; i++)
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // ---------------- stage 0: component products ----------------
    logic signed [2*QW-1:0] prod_reg [4];
    logic signed [QW-1:0]   pin [4];
    logic signed [QW-1:0]   qin [4];

    assign pin[0] = p_w;
    assign pin[1] = p_x;
    assign pin[2] = p_y;
    assign pin[3] = p_z;
    assign qin[0] = q_w;
    assign qin[1] = q_x;
    assign qin[2] = q_y;
    assign qin[3] = q_z;

    always_comb
    begin
        side_in = '0;
        for (int k = 0; k < 4; k++)
        begin
            side_in.p[k] = pin[k];
            side_in.q[k] = (QW+1)'(qin[k]);
        end
        // clamp t to one
        if (32'(t_weight) > 32'(ONE))
        begin
            side_in.t = TW'(ONE);
        end
        else
        begin
            side_in.t = t_weight;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= pin[k] * qin[k];
            end
        end
    end

    // ---------------- stage 1: dot product, short arc, cosine ----------------
    logic signed [2*QW+1:0] dot_sum;
    logic signed [2*QW+1:0] dot_abs;
    logic [2*QW+1:0]        dot_sh;
    logic                   dot_neg;
    logic [CW-1:0]          cos_c;
    logic [CW-1:0]          one_minus_c;
    logic                   lin_thr;

    always_comb
    begin
        dot_sum = (2*QW+2)'(prod_reg[0]) + (2*QW+2)'(prod_reg[1])
                + (2*QW+2)'(prod_reg[2]) + (2*QW+2)'(prod_reg[3]);
        dot_neg = dot_sum[2*QW+1];
        dot_abs = dot_neg ? -dot_sum : dot_sum;
        dot_sh  = $unsigned(dot_abs) >> F;
        cos_c   = (dot_sh > (2*QW+2)'(ONE)) ? CW'(ONE) : CW'(dot_sh);
        one_minus_c = CW'(ONE) - cos_c;
        lin_thr = !(32'(one_minus_c) > 32'(thr_reg));
    end

    // ---------------- stage 2: radicand one^2 - c^2 ----------------
    logic [RW-1:0] rad_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg <= (RW'(1) << (2*F))
                     - RW'(side_reg[P_RAD-1].c) * RW'(side_reg[P_RAD-1].c);
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic [RW-1:0]  sq_x_reg    [SB];
    logic [RMW-1:0] sq_rem_reg  [SB];
    logic [CW-1:0]  sq_root_reg [SB];
    logic [RW-1:0]  sq_x_next   [SB];
    logic [RMW-1:0] sq_rem_next [SB];
    logic [CW-1:0]  sq_root_next[SB];

    for (genvar j = 0; j < SB; j++)
    begin : g_sq
        logic [RW-1:0]  x_in;
        logic [RMW-1:0] rem_in;
        logic [CW-1:0]  root_in;
        logic [RMW+1:0] r2;
        logic [RMW+1:0] trial;

        if (j == 0)
        begin : g_first
            assign x_in    = rad_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign x_in    = sq_x_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
        end

        always_comb
        begin
            r2    = {rem_in, x_in[RW-1 -: 2]};
            trial = (RMW+2)'({root_in, 2'b01});
            if (r2 >= trial)
            begin
                sq_rem_next[j]  = RMW'(r2 - trial);
                sq_root_next[j] = {root_in[CW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[j]  = RMW'(r2);
                sq_root_next[j] = {root_in[CW-2:0], 1'b0};
            end
            sq_x_next[j] = x_in << 2;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_x_reg[j]    <= sq_x_next[j];
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
            end
        end
    end

    // ---------------- side band propagation ----------------
    always_comb
    begin
        side_next[0] = side_in;
        for (int i = 1; i < P_OUT; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        // take the short arc: negate q with a negative dot product
        for (int k = 0; k < 4; k++)
        begin
            side_next[P_DOT].q[k] = dot_neg ? -side_reg[P_DOT-1].q[k]
                                            : side_reg[P_DOT-1].q[k];
        end
        side_next[P_DOT].c   = cos_c;
        side_next[P_DOT].lin = lin_thr;
        // zero sine falls back to linear weights
        side_next[P_SQ+SB-1].s   = sq_root_next[SB-1];
        side_next[P_SQ+SB-1].lin = side_reg[P_SQ+SB-2].lin || (sq_root_next[SB-1] == '0);
    end

    // ---------------- vectoring CORDIC: arc angle ----------------
    logic signed [XW-1:0] vc_x_reg [N];
    logic signed [XW-1:0] vc_y_reg [N];
    logic signed [XW-1:0] vc_z_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_vc
        localparam longint AI = (longint'(ATAN_Q30[i]) + HALF_Q) >>> SH;
        localparam logic signed [XW-1:0] ATAN_I = XW'(AI);
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [XW-1:0] z_in;

        if (i == 0)
        begin : g_first
            assign x_in = $signed(XW'(side_reg[P_VC-1].c));
            assign y_in = $signed(XW'(side_reg[P_VC-1].s));
            assign z_in = '0;
        end
        else
        begin : g_rest
            assign x_in = vc_x_reg[i-1];
            assign y_in = vc_y_reg[i-1];
            assign z_in = vc_z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!y_in[XW-1])
                begin
                    vc_x_reg[i] <= x_in + (y_in >>> i);
                    vc_y_reg[i] <= y_in - (x_in >>> i);
                    vc_z_reg[i] <= z_in + ATAN_I;
                end
                else
                begin
                    vc_x_reg[i] <= x_in - (y_in >>> i);
                    vc_y_reg[i] <= y_in + (x_in >>> i);
                    vc_z_reg[i] <= z_in - ATAN_I;
                end
            end
        end
    end

    // ---------------- split angle into (1-t)a and ta ----------------
    logic signed [XW-1:0] am_ang_reg [2];
    logic [CW-1:0]        ang_a;
    logic [CW-1:0]        t_c;
    logic [2*CW-1:0]      ua_prod;
    logic [2*CW-1:0]      ta_prod;

    always_comb
    begin
        ang_a   = vc_z_reg[N-1][XW-1] ? '0 : CW'(vc_z_reg[N-1]);
        t_c     = CW'(side_reg[P_AM-1].t);
        ua_prod = (2*CW)'(CW'(ONE) - t_c) * (2*CW)'(ang_a);
        ta_prod = (2*CW)'(t_c) * (2*CW)'(ang_a);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            am_ang_reg[0] <= $signed(XW'(ua_prod >> F));
            am_ang_reg[1] <= $signed(XW'(ta_prod >> F));
        end
    end

    // ---------------- rotation CORDIC: two sine lanes ----------------
    logic signed [XW-1:0] rc_x_reg [2][N];
    logic signed [XW-1:0] rc_y_reg [2][N];
    logic signed [XW-1:0] rc_z_reg [2][N];

    for (genvar l = 0; l < 2; l++)
    begin : g_rl
        for (genvar i = 0; i < N; i++)
        begin : g_rc
            localparam longint AI = (longint'(ATAN_Q30[i]) + HALF_Q) >>> SH;
            localparam logic signed [XW-1:0] ATAN_I = XW'(AI);
            logic signed [XW-1:0] x_in;
            logic signed [XW-1:0] y_in;
            logic signed [XW-1:0] z_in;

            if (i == 0)
            begin : g_first
                assign x_in = XW'(X0_L);
                assign y_in = '0;
                assign z_in = am_ang_reg[l];
            end
            else
            begin : g_rest
                assign x_in = rc_x_reg[l][i-1];
                assign y_in = rc_y_reg[l][i-1];
                assign z_in = rc_z_reg[l][i-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!z_in[XW-1])
                    begin
                        rc_x_reg[l][i] <= x_in - (y_in >>> i);
                        rc_y_reg[l][i] <= y_in + (x_in >>> i);
                        rc_z_reg[l][i] <= z_in - ATAN_I;
                    end
                    else
                    begin
                        rc_x_reg[l][i] <= x_in + (y_in >>> i);
                        rc_y_reg[l][i] <= y_in - (x_in >>> i);
                        rc_z_reg[l][i] <= z_in + ATAN_I;
                    end
                end
            end
        end
    end

    // ---------------- divide sines by sin(a), one quotient bit per stage ----------------
    logic [NW-1:0]  da_num_reg [2];
    logic           da_neg_reg [2];
    logic [NW-1:0]  dv_num_reg [2][QB];
    logic [DRW-1:0] dv_rem_reg [2][QB];
    logic [NW-1:0]  dv_q_reg   [2][QB];
    logic           dv_neg_reg [2][QB];

    for (genvar l = 0; l < 2; l++)
    begin : g_dl
        logic signed [XW-1:0] y_fin;
        logic [XW-1:0]        y_mag;

        always_comb
        begin
            y_fin = rc_y_reg[l][N-1];
            y_mag = y_fin[XW-1] ? $unsigned(-y_fin) : $unsigned(y_fin);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                da_num_reg[l] <= {y_mag, {F{1'b0}}};
                da_neg_reg[l] <= y_fin[XW-1];
            end
        end

        for (genvar j = 0; j < QB; j++)
        begin : g_dv
            logic [NW-1:0]  num_in;
            logic [DRW-1:0] rem_in;
            logic [NW-1:0]  q_in;
            logic           neg_in;
            logic [DRW:0]   r;
            logic [DRW:0]   dvs;

            if (j == 0)
            begin : g_first
                assign num_in = da_num_reg[l];
                assign rem_in = '0;
                assign q_in   = '0;
                assign neg_in = da_neg_reg[l];
            end
            else
            begin : g_rest
                assign num_in = dv_num_reg[l][j-1];
                assign rem_in = dv_rem_reg[l][j-1];
                assign q_in   = dv_q_reg[l][j-1];
                assign neg_in = dv_neg_reg[l][j-1];
            end

            always_comb
            begin
                r   = {rem_in, num_in[NW-1]};
                dvs = (DRW+1)'(side_reg[P_DV+j-1].s);
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (r >= dvs)
                    begin
                        dv_rem_reg[l][j] <= DRW'(r - dvs);
                        dv_q_reg[l][j]   <= {q_in[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[l][j] <= DRW'(r);
                        dv_q_reg[l][j]   <= {q_in[NW-2:0], 1'b0};
                    end
                    dv_num_reg[l][j] <= num_in << 1;
                    dv_neg_reg[l][j] <= neg_in;
                end
            end
        end
    end

    // ---------------- weights: sign, clamp, linear fallback ----------------
    logic signed [WW-1:0] wf_w_reg [2];
    logic signed [WW-1:0] w_slerp [2];
    logic [WW-1:0]        w_mag [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (dv_q_reg[l][QB-1] > NW'(2 * ONE))
            begin
                w_mag[l] = WW'(2 * ONE);
            end
            else
            begin
                w_mag[l] = WW'(dv_q_reg[l][QB-1]);
            end
            w_slerp[l] = dv_neg_reg[l][QB-1] ? -$signed(w_mag[l]) : $signed(w_mag[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (side_reg[P_WF-1].lin)
            begin
                wf_w_reg[0] <= $signed(WW'(ONE) - WW'(side_reg[P_WF-1].t));
                wf_w_reg[1] <= $signed(WW'(side_reg[P_WF-1].t));
            end
            else
            begin
                wf_w_reg[0] <= w_slerp[0];
                wf_w_reg[1] <= w_slerp[1];
            end
        end
    end

    // ---------------- weighted products ----------------
    logic signed [MW-1:0] wm_p_reg [4];
    logic signed [MW-1:0] wm_q_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                wm_p_reg[k] <= wf_w_reg[0] * $signed(side_reg[P_WM-1].p[k]);
                wm_q_reg[k] <= wf_w_reg[1] * $signed(side_reg[P_WM-1].q[k]);
            end
        end
    end

    // ---------------- round, shift, saturate ----------------
    logic signed [QW-1:0] out_reg [4];
    logic                 lin_out_reg;
    logic signed [MW:0]   acc [4];
    logic signed [MW:0]   acc_sh [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            acc[k]    = (MW+1)'(wm_p_reg[k]) + (MW+1)'(wm_q_reg[k]) + (MW+1)'(ONE >> 1);
            acc_sh[k] = acc[k] >>> F;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (acc_sh[k] > (MW+1)'(32767))
                begin
                    out_reg[k] <= 16'sh7FFF;
                end
                else if (acc_sh[k] < -(MW+1)'(32768))
                begin
                    out_reg[k] <= -16'sh8000;
                end
                else
                begin
                    out_reg[k] <= QW'(acc_sh[k]);
                end
            end
            lin_out_reg <= side_reg[P_OUT-1].lin;
        end
    end

    assign out_w       = out_reg[0];
    assign out_x       = out_reg[1];
    assign out_y       = out_reg[2];
    assign out_z       = out_reg[3];
    assign used_linear = lin_out_reg;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for quaternion_slerp_interpolator: directed table plus random
// pairs, mostly unit quaternions, checked against a behavioral slerp predictor or fixed results.
// Depends on qslerp_pkg and the DUT.
module tb_top;
    import qslerp_pkg::*;

    localparam longint ONE = 64'sd1 << 14;
    localparam int STEPS = 16;
    localparam int LATENCY = 86;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [QW-1:0] w, x, y, z;
        logic                 lin;
    } slerp_out_t;

    typedef struct {
        logic signed [QW-1:0] p [4];
        logic signed [QW-1:0] q [4];
        logic [TW-1:0]        t;
        bit                   typed;
        slerp_out_t           res;
    } stim_row_t;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [QW-1:0] pv [4];
    logic signed [QW-1:0] qv [4];
    logic [TW-1:0] t_weight;
    logic signed [QW-1:0] out_w, out_x, out_y, out_z;
    logic used_linear;

    slerp_out_t pending_results[$];
    logic [THR_W-1:0] near_thr;
    int errors;
    int cycles = 0;
    bit no_idle;

    quaternion_slerp_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .p_w(pv[0]), .p_x(pv[1]), .p_y(pv[2]), .p_z(pv[3]),
        .q_w(qv[0]), .q_x(qv[1]), .q_y(qv[2]), .q_z(qv[3]),
        .t_weight(t_weight),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .used_linear(used_linear)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint atan_step(input int i);
        return (longint'(ATAN_Q30[i]) + 32768) >>> 16;
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic longint arc_angle(input longint x, input longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint arc_sine(input longint z);
        longint x, y, xs, ys;
        x = (longint'(CORDIC_GAIN_Q30) + 32768) >>> 16;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end
        end
        return y;
    endfunction

    function automatic longint clamp_wt(input longint w);
        if (w > 2 * ONE) return 2 * ONE;
        if (w < -2 * ONE) return -2 * ONE;
        return w;
    endfunction

    function automatic slerp_out_t predict_slerp(input stim_row_t r, input logic [THR_W-1:0] thr);
        longint p [4];
        longint q [4];
        longint t, dot, c, s, a, w0, w1, v;
        bit lin;
        slerp_out_t o;
        for (int k = 0; k < 4; k++)
        begin
            p[k] = r.p[k];
            q[k] = r.q[k];
        end
        t = r.t;
        if (t > ONE) t = ONE;
        dot = p[0]*q[0] + p[1]*q[1] + p[2]*q[2] + p[3]*q[3];
        if (dot < 0)
        begin
            dot = -dot;
            for (int k = 0; k < 4; k++) q[k] = -q[k];
        end
        c = dot >>> 14;
        if (c > ONE) c = ONE;
        lin = !((ONE - c) > longint'(thr));
        s = 0;
        if (!lin)
        begin
            s = int_sqrt(longint'(ONE * ONE - c * c));
            if (s == 0) lin = 1;
        end
        if (lin)
        begin
            w0 = ONE - t;
            w1 = t;
        end
        else
        begin
            a = arc_angle(c, s);
            if (a < 0) a = 0;
            w0 = clamp_wt(arc_sine(((ONE - t) * a) >>> 14) * ONE / s);
            w1 = clamp_wt(arc_sine((t * a) >>> 14) * ONE / s);
        end
        for (int k = 0; k < 4; k++)
        begin
            v = (w0 * p[k] + w1 * q[k] + (ONE >> 1)) >>> 14;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            case (k)
                0: o.w = v[15:0];
                1: o.x = v[15:0];
                2: o.y = v[15:0];
                default: o.z = v[15:0];
            endcase
        end
        o.lin = lin;
        return o;
    endfunction

    function automatic stim_row_t mk_row(input int pw, px, py, pz, qw, qx, qy, qz, tt);
        stim_row_t r;
        r.p[0] = QW'(pw); r.p[1] = QW'(px); r.p[2] = QW'(py); r.p[3] = QW'(pz);
        r.q[0] = QW'(qw); r.q[1] = QW'(qx); r.q[2] = QW'(qy); r.q[3] = QW'(qz);
        r.t = TW'(tt);
        r.typed = 0;
        return r;
    endfunction

    function automatic stim_row_t rand_row();
        stim_row_t r;
        real u [4];
        real n;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            for (int k = 0; k < 4; k++)
            begin
                r.p[k] = QW'($urandom);
                r.q[k] = QW'($urandom);
            end
        end
        else
        begin
            n = 0.0;
            for (int k = 0; k < 4; k++)
            begin
                u[k] = real'(int'($urandom_range(0, 2000)) - 1000) + 0.5;
                n = n + u[k] * u[k];
            end
            n = $sqrt(n);
            for (int k = 0; k < 4; k++)
                r.p[k] = QW'($rtoi(u[k] / n * 16384.0));
            for (int k = 0; k < 4; k++)
            begin
                // near pairs exercise the threshold; others take a fresh direction
                if (mode < 6)
                    r.q[k] = QW'(int'(r.p[k]) + int'($urandom_range(0, 2 * mode)) - mode);
                else
                    u[k] = real'(int'($urandom_range(0, 2000)) - 1000) + 0.5;
            end
            if (mode >= 6)
            begin
                n = $sqrt(u[0]*u[0] + u[1]*u[1] + u[2]*u[2] + u[3]*u[3]);
                for (int k = 0; k < 4; k++)
                    r.q[k] = QW'($rtoi(u[k] / n * 16384.0));
            end
            if ($urandom_range(0, 1))
                for (int k = 0; k < 4; k++) r.q[k] = -r.q[k];
        end
        r.t = ($urandom_range(0, 7) == 0) ? TW'($urandom) : TW'($urandom_range(0, 16384));
        r.typed = 0;
        return r;
    endfunction

    task automatic drive_item(input stim_row_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            pv[k] <= r.p[k];
            qv[k] <= r.q[k];
        end
        t_weight <= r.t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(r.typed ? r.res : predict_slerp(r, near_thr));
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_thr(input logic [THR_W-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_NEAR_THR, 2'b00}; pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        near_thr = val;
        // read back
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[THR_W-1:0] !== val)
        begin
            $display("%0t near_threshold readback: expected %0d actual %0d", $time, val,
                     prdata[THR_W-1:0]);
            errors++;
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge clk);
    endtask

    // receive side: draw a stall per beat, compare with the oldest expectation
    initial
    begin
        slerp_out_t e;
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected beat: actual w=%0d x=%0d y=%0d z=%0d lin=%0b",
                         $time, out_w, out_x, out_y, out_z, used_linear);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_w !== e.w)
                begin
                    $display("%0t out_w: expected %0d actual %0d", $time, e.w, out_w);
                    errors++;
                end
                if (out_x !== e.x)
                begin
                    $display("%0t out_x: expected %0d actual %0d", $time, e.x, out_x);
                    errors++;
                end
                if (out_y !== e.y)
                begin
                    $display("%0t out_y: expected %0d actual %0d", $time, e.y, out_y);
                    errors++;
                end
                if (out_z !== e.z)
                begin
                    $display("%0t out_z: expected %0d actual %0d", $time, e.z, out_z);
                    errors++;
                end
                if (used_linear !== e.lin)
                begin
                    $display("%0t used_linear: expected %0b actual %0b", $time, e.lin,
                             used_linear);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t directed [$];
        stim_row_t r;
        logic [THR_W-1:0] thr_plan [6];
        errors = 0;
        no_idle = 0;
        near_thr = NEAR_THR_RESET;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; t_weight = '0;
        for (int k = 0; k < 4; k++)
        begin
            pv[k] = '0;
            qv[k] = '0;
        end

        // identical quaternions: linear, returns p exactly
        r = mk_row(16384, 0, 0, 0, 16384, 0, 0, 0, 0);
        r.typed = 1; r.res = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1};
        directed.push_back(r);
        r.t = 16384;
        directed.push_back(r);
        // t above one, treated as one
        r.t = 15'h7FFF;
        directed.push_back(r);
        // all zero: orthogonal path, zero output
        r = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 8192);
        r.typed = 1; r.res = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0};
        directed.push_back(r);
        // opposite quaternions: q negated, shorter arc
        directed.push_back(mk_row(16384, 0, 0, 0, -16384, 0, 0, 0, 4096));
        directed.push_back(mk_row(0, 16384, 0, 0, 0, -16384, 0, 0, 16384));
        // orthogonal pairs across t values, and one oblique pair
        directed.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        directed.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
        directed.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
        directed.push_back(mk_row(0, 0, -16384, 0, 0, 0, 0, -16384, 12000));
        directed.push_back(mk_row(11585, 11585, 0, 0, 11585, 0, 11585, 0, 5000));
        directed.push_back(mk_row(8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192, 3000));
        // cosine above one and saturation
        directed.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                  8192));
        directed.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, 16384));
        directed.push_back(mk_row(32767, -32768, 32767, -32768, -32768, 32767, -32768,
                                  32767, 100));
        directed.push_back(mk_row(-1, -1, -1, -1, 1, 1, 1, 1, 15'h4001));
        // near-equal pairs, one minus cosine just around the reset threshold
        directed.push_back(mk_row(16384, 0, 0, 0, 16383, 181, 0, 0, 8192));
        directed.push_back(mk_row(16384, 0, 0, 0, 16380, 360, 0, 0, 8192));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            drive_item(directed[i]);
        drain_pipe();

        thr_plan = '{15'd0, 15'd16384, 15'h7FFF, 15'd0, 15'd100, 15'd2};
        thr_plan[3] = THR_W'($urandom_range(0, 16384));
        foreach (thr_plan[ph])
        begin
            write_thr(thr_plan[ph]);
            for (int n = 0; n < 67; n++)
            begin
                // hold bursts with no idling on either side now and then
                if (n % 20 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                drive_item(rand_row());
            end
            no_idle = 0;
            drain_pipe();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### sim.f
rtl/core/qslerp_pkg.sv
rtl/core/quaternion_slerp_interpolator.sv
tb/sv/tb_top.sv
